>>> src/refcounted_page_allocator_defines.svh
// assertion macros used by the allocator controller
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define RCPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rcpa_pkg.sv
// types and constants of the page allocator
package rcpa_pkg;

	localparam int ADDR_W = 24;
	localparam int REQ_W  = 3;
	localparam int CNT_W  = 8;
	localparam int STAT_W = 2;
	localparam int FP_W   = 12;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DROP  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADD   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INIT  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_PAGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;
	localparam logic [STAT_W-1:0] ST_FREE    = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	// decoded request handed from the top level to the controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             bad;
	} req_dec_t;

endpackage

>>> src/rcpa_req_if.sv
// request channel of the page allocator
interface rcpa_req_if import rcpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ADDR_W-1:0] address;

	modport source(output valid, req_type, address, input ready);
	modport sink(input valid, req_type, address, output ready);
endinterface

>>> src/rcpa_rsp_if.sv
// response channel of the page allocator
interface rcpa_rsp_if import rcpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] page_address;
	logic [CNT_W-1:0]  ref_count;
	logic              returned_to_pool;
	logic [STAT_W-1:0] status;

	modport source(output valid, page_address, ref_count, returned_to_pool, status,
		input ready);
	modport sink(input valid, page_address, ref_count, returned_to_pool, status,
		output ready);
endinterface

>>> src/rcpa_ram.sv
// simple dual-port synchronous ram with registered read data
module rcpa_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/rcpa_ctrl.sv
// request sequencer with count and freed-page memories and result register
`include "refcounted_page_allocator_defines.svh"

module rcpa_ctrl import rcpa_pkg::*; #(
	parameter int PAGE_COUNT = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [FP_W-1:0]               first_page,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  req_dec_t                      in_dec,
	input  logic [$clog2(PAGE_COUNT)-1:0] in_page,
	rcpa_rsp_if.source                    rsp
);

	localparam int PW   = $clog2(PAGE_COUNT);
	localparam int CNTW = $clog2(PAGE_COUNT + 1);
	localparam int CW   = (CNTW > FP_W) ? CNTW : FP_W;
	localparam int BSH  = $clog2(PAGE_BYTES);
	localparam int SHW  = PW + BSH;
	localparam logic [PW-1:0] LAST_IDX = PW'(PAGE_COUNT - 1);

	state_t state_q, state_d;

	logic [CNTW-1:0] depth_q;
	logic [CNTW-1:0] untouched_q;
	logic [PW-1:0]   clr_q;
	logic            init_q;

	req_dec_t      dec_s1;
	logic [PW-1:0] page_s1;

	logic              out_valid_q;
	logic [ADDR_W-1:0] page_addr_q;
	logic [CNT_W-1:0]  ref_cnt_q;
	logic              ret_q;
	logic [STAT_W-1:0] stat_q;

	logic              out_free;
	logic              accept;
	logic              cnt_we;
	logic [PW-1:0]     cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [CNT_W-1:0]  cnt_rdata;
	logic              stk_we;
	logic [PW-1:0]     stk_rdata;
	logic              res_load;
	logic [ADDR_W-1:0] res_page;
	logic [CNT_W-1:0]  res_cnt;
	logic              res_ret;
	logic [STAT_W-1:0] res_stat;
	logic              pop;
	logic              take_untouched;
	logic              push_inc;
	logic              init_go;
	logic              have_stack;
	logic              have_untouched;
	logic [PW-1:0]     page_alloc;
	logic [SHW-1:0]    alloc_addr_wide;

	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = in_valid && in_ready;

	// count store, cleared by the sweep
	rcpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(CNT_W)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (accept),
		.raddr (in_page),
		.rdata (cnt_rdata)
	);

	// freed-page stack, only read below the depth
	rcpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(PW)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[PW-1:0]),
		.wdata (page_s1),
		.re    (accept),
		.raddr (PW'(depth_q - 1'b1)),
		.rdata (stk_rdata)
	);

	assign have_stack     = depth_q != '0;
	assign have_untouched = (CW'(untouched_q) > CW'(first_page)) && (untouched_q != '0);
	assign page_alloc     = have_stack ? stk_rdata : PW'(untouched_q - 1'b1);
	assign alloc_addr_wide = SHW'(page_alloc) << BSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cnt_we         = 1'b0;
		cnt_waddr      = page_s1;
		cnt_wdata      = '0;
		stk_we         = 1'b0;
		res_load       = 1'b0;
		res_page       = '0;
		res_cnt        = '0;
		res_ret        = 1'b0;
		res_stat       = ST_OK;
		pop            = 1'b0;
		take_untouched = 1'b0;
		push_inc       = 1'b0;
		init_go        = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					if (!init_q) begin
						state_d = S_IDLE;
					end else if (out_free) begin
						res_load = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d  = S_IDLE;
					res_load = 1'b1;
					if (dec_s1.req == REQ_ALLOC) begin
						if (have_stack || have_untouched) begin
							pop            = have_stack;
							take_untouched = !have_stack;
							cnt_we         = 1'b1;
							cnt_waddr      = page_alloc;
							cnt_wdata      = CNT_W'(1);
							res_page       = ADDR_W'(alloc_addr_wide);
							res_cnt        = CNT_W'(1);
						end else begin
							res_stat = ST_NO_PAGE;
						end
					end else if (dec_s1.req == REQ_DROP || dec_s1.req == REQ_ADD
						|| dec_s1.req == REQ_READ) begin
						if (dec_s1.bad) begin
							res_stat = ST_BAD;
						end else if (dec_s1.req == REQ_READ) begin
							res_cnt = cnt_rdata;
						end else if (cnt_rdata == '0) begin
							res_stat = ST_FREE;
						end else if (dec_s1.req == REQ_DROP) begin
							cnt_we    = 1'b1;
							cnt_wdata = cnt_rdata - 1'b1;
							res_cnt   = cnt_rdata - 1'b1;
							if (cnt_rdata == CNT_W'(1)) begin
								res_ret = 1'b1;
								// a push onto a full stack is dropped
								if (depth_q < CNTW'(PAGE_COUNT)) begin
									stk_we   = 1'b1;
									push_inc = 1'b1;
								end
							end
						end else begin
							cnt_we    = 1'b1;
							cnt_wdata = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + 1'b1;
							res_cnt   = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + 1'b1;
						end
					end else if (dec_s1.req == REQ_INIT) begin
						// result waits for the end of the sweep
						init_go  = 1'b1;
						res_load = 1'b0;
						state_d  = S_CLEAR;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			untouched_q <= CNTW'(PAGE_COUNT);
			clr_q       <= '0;
			init_q      <= 1'b0;
		end else begin
			if (state_q == S_CLEAR && clr_q != LAST_IDX) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_CLEAR && res_load) begin
				init_q <= 1'b0;
			end
			if (init_go) begin
				depth_q     <= '0;
				untouched_q <= CNTW'(PAGE_COUNT);
				clr_q       <= '0;
				init_q      <= 1'b1;
			end
			if (pop) begin
				depth_q <= depth_q - 1'b1;
			end
			if (push_inc) begin
				depth_q <= depth_q + 1'b1;
			end
			if (take_untouched) begin
				untouched_q <= untouched_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1  <= in_dec;
			page_s1 <= in_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			page_addr_q <= res_page;
			ref_cnt_q   <= res_cnt;
			ret_q       <= res_ret;
			stat_q      <= res_stat;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.page_address     = page_addr_q;
	assign rsp.ref_count        = ref_cnt_q;
	assign rsp.returned_to_pool = ret_q;
	assign rsp.status           = stat_q;

	`RCPA_ASSERT_NXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC,
		"accepted item did not move to execute")
	`RCPA_ASSERT_IMP(a_err_zero, clk, arst_n, res_load && res_stat != ST_OK,
		res_cnt == '0 && res_page == '0 && !res_ret, "error result carries data")
	`RCPA_ASSERT_IMP(a_ret_drop, clk, arst_n, res_load && res_ret,
		res_cnt == '0 && dec_s1.req == REQ_DROP, "page returned by something other than a drop")
	`RCPA_ASSERT_NXT(a_untouched_down, clk, arst_n, state_q == S_EXEC && dec_s1.req == REQ_ALLOC,
		untouched_q <= $past(untouched_q), "untouched mark grew on allocate")
	`RCPA_ASSERT_IMP(a_depth_max, clk, arst_n, 1'b1, depth_q <= CNTW'(PAGE_COUNT),
		"freed stack depth beyond pool size")

endmodule

>>> src/refcounted_page_allocator.sv
// top level of the reference-counted page allocator
// every request is accepted, then executed as one count/stack read-modify-write
// the result is registered once the output is free; one item is in flight at a time
// initialize sweeps the count memory, one entry a cycle, and gives its result at the end
// after reset the same sweep runs with ready low
module refcounted_page_allocator import rcpa_pkg::*; #(
	parameter int PAGE_COUNT = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	rcpa_req_if.sink        req,
	rcpa_rsp_if.source      rsp,
	input  logic            cfg_we,
	input  logic [FP_W-1:0] cfg_wdata
);

	// page index width and byte offset width within a page
	localparam int PW   = $clog2(PAGE_COUNT);
	localparam int BSH  = $clog2(PAGE_BYTES);
	// wide enough for page numbers, first_page and the pool size
	localparam int CMPW = ADDR_W + 1;

	// lowest page of the pool; to be written only while idle, which the block does not enforce
	logic [FP_W-1:0] first_page_q;

	logic [ADDR_W-BSH-1:0] page_full;
	logic                  misaligned;
	logic                  below_pool;
	logic                  above_pool;
	req_dec_t              dec;
	logic [PW-1:0]         page_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
		end else if (cfg_we) begin
			first_page_q <= cfg_wdata;
		end
	end

	// page number is the address above the in-page offset
	assign page_full  = req.address[ADDR_W-1:BSH];
	// any offset bit set means the address is not page aligned
	assign misaligned = |req.address[BSH-1:0];
	assign below_pool = CMPW'(page_full) < CMPW'(first_page_q);
	assign above_pool = CMPW'(page_full) >= CMPW'(PAGE_COUNT);

	assign dec.req = req.req_type;
	assign dec.bad = misaligned || below_pool || above_pool;
	// memory index; only meaningful when the address is in range
	assign page_idx = PW'(CMPW'(page_full));

	// sequencer owns the count memory, the freed stack and the result register
	rcpa_ctrl #(
		.PAGE_COUNT (PAGE_COUNT),
		.PAGE_BYTES (PAGE_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.first_page (first_page_q),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_dec     (dec),
		.in_page    (page_idx),
		.rsp        (rsp)
	);

endmodule
